// File: hw/rtl/pidtc_pkg.sv
// ----------------------------------------------------------------------------
// pidtc_pkg: shared types and helpers for the time corrected pid controller
// Q16.16 payload types, register indexes, step counts and saturation helpers.
// ----------------------------------------------------------------------------
package pidtc_pkg;

  localparam int DataW    = 32;
  localparam int FactorW  = 16;
  localparam int ProdW    = 2 * DataW;
  localparam int QuotW    = ProdW - 16;
  localparam int MulSteps = DataW;
  localparam int DivSteps = QuotW;
  localparam int CntW     = $clog2(DivSteps);
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegGainP         = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI         = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD         = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinSample     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIntegralLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTimeCorr      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInitTarget    = 3'd6;

  localparam logic [FactorW-1:0] MinSampleReset = 16'd10;
  localparam logic [FactorW-1:0] FactorCap      = 16'hFFFF;
  localparam logic [FactorW-1:0] FactorOne      = 16'd1;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  typedef struct packed {
    logic                    op;
    logic [DataW-1:0]        now_ms;
    logic signed [DataW-1:0] measurement;
    logic signed [DataW-1:0] new_target;
    logic                    clear_integral;
  } pidtc_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    evaluated;
  } pidtc_result_t;

  typedef struct packed {
    logic load;
    logic step;
  } pidtc_seq_t;

  function automatic logic [DataW-1:0] abs32(input logic [DataW-1:0] v);
    return v[DataW-1] ? (~v + 1'b1) : v;
  endfunction

  // clamp a 34 bit sum to the signed 32 bit range
  function automatic logic signed [DataW-1:0] sat_sum(input logic signed [DataW+1:0] v);
    logic fits;
    fits = (v[DataW+1:DataW-1] == 3'b000) || (v[DataW+1:DataW-1] == 3'b111);
    if (fits) begin
      return v[DataW-1:0];
    end
    return v[DataW+1] ? SatMin : SatMax;
  endfunction

  // apply a sign to a magnitude and clamp to the signed 32 bit range
  function automatic logic signed [DataW-1:0] sat_mag(input logic neg,
                                                      input logic [QuotW-1:0] mag);
    logic over;
    logic [DataW-1:0] low;
    low = mag[DataW-1:0];
    if (neg) begin
      over = (|mag[QuotW-1:DataW]) || (mag[DataW-1] && (|mag[DataW-2:0]));
    end else begin
      over = |mag[QuotW-1:DataW-1];
    end
    if (over) begin
      return neg ? SatMin : SatMax;
    end
    return neg ? (~low + 1'b1) : low;
  endfunction

endpackage

// File: hw/rtl/pidtc_mul.sv
// ----------------------------------------------------------------------------
// pidtc_mul: shift-add multiplier
// Unsigned 32 x 32 product, one multiplier bit per step, lsb first.
// ----------------------------------------------------------------------------
module pidtc_mul (
  input  logic                           clk,
  input  pidtc_pkg::pidtc_seq_t          ctl,
  input  logic [pidtc_pkg::DataW-1:0]    a,
  input  logic [pidtc_pkg::DataW-1:0]    b,
  output logic [pidtc_pkg::ProdW-1:0]    prod
);

  logic [pidtc_pkg::DataW-1:0] mcand;
  logic [pidtc_pkg::DataW:0]   partial;

  assign partial = {1'b0, prod[pidtc_pkg::ProdW-1:pidtc_pkg::DataW]} +
                   (prod[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand <= a;
      prod  <= {{pidtc_pkg::DataW{1'b0}}, b};
    end else if (ctl.step) begin
      prod  <= {partial, prod[pidtc_pkg::DataW-1:1]};
    end
  end

endmodule

// File: hw/rtl/pidtc_div.sv
// ----------------------------------------------------------------------------
// pidtc_div: restoring divider
// 48 bit dividend by 16 bit divisor, one quotient bit per step, msb first.
// ----------------------------------------------------------------------------
module pidtc_div (
  input  logic                            clk,
  input  pidtc_pkg::pidtc_seq_t           ctl,
  input  logic [pidtc_pkg::QuotW-1:0]     dividend,
  input  logic [pidtc_pkg::FactorW-1:0]   divisor,
  output logic [pidtc_pkg::QuotW-1:0]     quotient
);

  logic [pidtc_pkg::FactorW-1:0] dsor;
  logic [pidtc_pkg::FactorW-1:0] rem;
  logic [pidtc_pkg::FactorW:0]   trial;
  logic [pidtc_pkg::FactorW:0]   diff;
  logic                          ge;

  assign trial = {rem, quotient[pidtc_pkg::QuotW-1]};
  assign diff  = trial - {1'b0, dsor};
  assign ge    = ~diff[pidtc_pkg::FactorW];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dsor     <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (ctl.step) begin
      rem      <= ge ? diff[pidtc_pkg::FactorW-1:0] : trial[pidtc_pkg::FactorW-1:0];
      quotient <= {quotient[pidtc_pkg::QuotW-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/pid_controller_time_corrected.sv
// ----------------------------------------------------------------------------
// pid_controller_time_corrected: Q16.16 pid regulator with anti-windup
// One item is worked at a time. A change-target beat or a sample that comes
// too early goes from the check state straight to the finish state, and the
// input opens again when its result is registered. An evaluating sample runs
// the check and diff states, then 32 steps of the shift-add multipliers
// (p, i and d products run side by side), then 48 steps of the restoring
// divider that scales the derivative by elapsed time (the integral step
// multiply runs alongside it), then the term, accumulate and sum states of
// saturating adds. A finished result waits in the output register while the
// next item is accepted. The setpoint returns to zero on reset; writes to the
// initial target register have no effect.
// ----------------------------------------------------------------------------
module pid_controller_time_corrected (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  pidtc_pkg::pidtc_item_t             item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output pidtc_pkg::pidtc_result_t           result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidtc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pidtc_pkg::DataW-1:0]        cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_PREP   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_TERM   = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state;
  logic [pidtc_pkg::CntW-1:0] cnt;

  // configuration
  logic signed [pidtc_pkg::DataW-1:0] gain_p;
  logic signed [pidtc_pkg::DataW-1:0] gain_i;
  logic signed [pidtc_pkg::DataW-1:0] gain_d;
  logic [pidtc_pkg::FactorW-1:0]      min_sample_ms;
  logic [pidtc_pkg::DataW-2:0]        integral_limit;
  logic                               time_correction_on;

  // controller state
  logic signed [pidtc_pkg::DataW-1:0] setpoint;
  logic signed [pidtc_pkg::DataW-1:0] integral_acc;
  logic signed [pidtc_pkg::DataW-1:0] previous_error;
  logic signed [pidtc_pkg::DataW-1:0] last_drive;
  logic [pidtc_pkg::DataW-1:0]        last_update_ms;
  logic                               has_run;

  // working registers
  pidtc_pkg::pidtc_item_t             held;
  logic signed [pidtc_pkg::DataW-1:0] error;
  logic signed [pidtc_pkg::DataW-1:0] diff;
  logic [pidtc_pkg::FactorW-1:0]      factor;
  logic signed [pidtc_pkg::DataW-1:0] p_term;
  logic signed [pidtc_pkg::DataW-1:0] qi;
  logic signed [pidtc_pkg::DataW-1:0] i_step;
  logic signed [pidtc_pkg::DataW-1:0] d_term;
  logic                               evaluated;

  logic [pidtc_pkg::DataW-1:0]        elapsed;
  logic                               too_early;
  logic [pidtc_pkg::FactorW-1:0]      factor_next;
  logic signed [pidtc_pkg::DataW-1:0] error_next;
  logic signed [pidtc_pkg::DataW-1:0] diff_next;
  logic signed [pidtc_pkg::DataW-1:0] prev_shift;
  logic signed [pidtc_pkg::DataW-1:0] qi_next;
  logic signed [pidtc_pkg::DataW-1:0] integral_next;
  logic signed [pidtc_pkg::DataW-1:0] drive_next;
  logic [pidtc_pkg::DataW-1:0]        drive_mag;
  logic                               sign_differs;
  logic                               integrate_ok;
  logic                               prod_zero;
  logic                               drive_zero;

  pidtc_pkg::pidtc_seq_t              ctl_pd;
  pidtc_pkg::pidtc_seq_t              ctl_i;
  pidtc_pkg::pidtc_seq_t              ctl_div;
  logic [pidtc_pkg::DataW-1:0]        mul_i_a;
  logic [pidtc_pkg::DataW-1:0]        mul_i_b;
  logic [pidtc_pkg::ProdW-1:0]        prod_p;
  logic [pidtc_pkg::ProdW-1:0]        prod_i;
  logic [pidtc_pkg::ProdW-1:0]        prod_d;
  logic [pidtc_pkg::QuotW-1:0]        quot;

  logic result_take;

  assign item_stall  = rst || (state != S_IDLE);
  assign cfg_ready   = !rst;
  assign result_take = result_valid && !result_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p             <= '0;
      gain_i             <= '0;
      gain_d             <= '0;
      min_sample_ms      <= pidtc_pkg::MinSampleReset;
      integral_limit     <= '0;
      time_correction_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidtc_pkg::RegGainP:         gain_p <= cfg_data;
        pidtc_pkg::RegGainI:         gain_i <= cfg_data;
        pidtc_pkg::RegGainD:         gain_d <= cfg_data;
        pidtc_pkg::RegMinSample:     min_sample_ms <= cfg_data[pidtc_pkg::FactorW-1:0];
        pidtc_pkg::RegIntegralLimit: integral_limit <= cfg_data[pidtc_pkg::DataW-2:0];
        pidtc_pkg::RegTimeCorr:      time_correction_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath arithmetic
  always_comb begin
    elapsed    = held.now_ms - last_update_ms;
    too_early  = elapsed <= {{(pidtc_pkg::DataW-pidtc_pkg::FactorW){1'b0}}, min_sample_ms};
    if (!time_correction_on) begin
      factor_next = pidtc_pkg::FactorOne;
    end else if (|elapsed[pidtc_pkg::DataW-1:pidtc_pkg::FactorW]) begin
      factor_next = pidtc_pkg::FactorCap;
    end else begin
      factor_next = elapsed[pidtc_pkg::FactorW-1:0];
    end
    error_next = pidtc_pkg::sat_sum({{2{setpoint[31]}}, setpoint} -
                                    {{2{held.measurement[31]}}, held.measurement});
    diff_next  = pidtc_pkg::sat_sum({{2{error[31]}}, error} -
                                    {{2{previous_error[31]}}, previous_error});
    prev_shift = pidtc_pkg::sat_sum({{2{previous_error[31]}}, previous_error} +
                                    {{2{held.new_target[31]}}, held.new_target} -
                                    {{2{setpoint[31]}}, setpoint});
    qi_next    = pidtc_pkg::sat_mag(gain_i[31] ^ error[31], prod_i[pidtc_pkg::ProdW-1:16]);
    integral_next = pidtc_pkg::sat_sum({{2{integral_acc[31]}}, integral_acc} +
                                       {{2{i_step[31]}}, i_step});
    drive_next = pidtc_pkg::sat_sum({{2{p_term[31]}}, p_term} +
                                    {{2{integral_acc[31]}}, integral_acc} +
                                    {{2{d_term[31]}}, d_term});
    drive_mag  = pidtc_pkg::abs32(last_drive);
    prod_zero  = (gain_i == '0) || (error == '0);
    drive_zero = (last_drive == '0);
    sign_differs = (prod_zero != drive_zero) ||
                   (!prod_zero && ((gain_i[31] ^ error[31]) != last_drive[31]));
    integrate_ok = (integral_limit == '0) || (drive_mag < {1'b0, integral_limit}) ||
                   sign_differs;
  end

  // sequencing of the serial units
  always_comb begin
    ctl_pd.load  = (state == S_DIFF);
    ctl_pd.step  = (state == S_MUL);
    ctl_i.load   = (state == S_DIFF) || (state == S_PREP);
    ctl_i.step   = (state == S_MUL) ||
                   ((state == S_DIV) && (cnt < pidtc_pkg::CntW'(pidtc_pkg::MulSteps)));
    ctl_div.load = (state == S_PREP);
    ctl_div.step = (state == S_DIV);
    if (state == S_PREP) begin
      mul_i_a = pidtc_pkg::abs32(qi_next);
      mul_i_b = {{(pidtc_pkg::DataW-pidtc_pkg::FactorW){1'b0}}, factor};
    end else begin
      mul_i_a = pidtc_pkg::abs32(gain_i);
      mul_i_b = pidtc_pkg::abs32(error);
    end
  end

  pidtc_mul u_mul_p (
    .clk  (clk),
    .ctl  (ctl_pd),
    .a    (pidtc_pkg::abs32(gain_p)),
    .b    (pidtc_pkg::abs32(error)),
    .prod (prod_p)
  );

  pidtc_mul u_mul_i (
    .clk  (clk),
    .ctl  (ctl_i),
    .a    (mul_i_a),
    .b    (mul_i_b),
    .prod (prod_i)
  );

  pidtc_mul u_mul_d (
    .clk  (clk),
    .ctl  (ctl_pd),
    .a    (pidtc_pkg::abs32(gain_d)),
    .b    (pidtc_pkg::abs32(diff_next)),
    .prod (prod_d)
  );

  pidtc_div u_div (
    .clk      (clk),
    .ctl      (ctl_div),
    .dividend (prod_d[pidtc_pkg::ProdW-1:16]),
    .divisor  (factor),
    .quotient (quot)
  );

  // control and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      result_valid   <= 1'b0;
      setpoint       <= '0;
      integral_acc   <= '0;
      previous_error <= '0;
      last_drive     <= '0;
      last_update_ms <= '0;
      has_run        <= 1'b0;
    end else begin
      if (result_take && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            held  <= item;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (held.op) begin
            previous_error <= prev_shift;
            setpoint       <= held.new_target;
            last_update_ms <= held.now_ms;
            if (held.clear_integral) begin
              integral_acc <= '0;
            end
            evaluated <= 1'b0;
            state     <= S_FINISH;
          end else if (too_early) begin
            evaluated <= 1'b0;
            state     <= S_FINISH;
          end else begin
            last_update_ms <= held.now_ms;
            factor         <= factor_next;
            error          <= error_next;
            state          <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff  <= diff_next;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == pidtc_pkg::CntW'(pidtc_pkg::MulSteps - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          p_term <= pidtc_pkg::sat_mag(gain_p[31] ^ error[31],
                                       prod_p[pidtc_pkg::ProdW-1:16]);
          qi     <= qi_next;
          cnt    <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == pidtc_pkg::CntW'(pidtc_pkg::DivSteps - 1)) begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          i_step <= pidtc_pkg::sat_mag(qi[31], prod_i[pidtc_pkg::QuotW-1:0]);
          d_term <= has_run ? pidtc_pkg::sat_mag(gain_d[31] ^ diff[31], quot) : '0;
          state  <= S_ACC;
        end
        S_ACC: begin
          if (has_run && integrate_ok) begin
            integral_acc <= integral_next;
          end
          state <= S_SUM;
        end
        S_SUM: begin
          last_drive     <= drive_next;
          previous_error <= error;
          has_run        <= 1'b1;
          evaluated      <= 1'b1;
          state          <= S_FINISH;
        end
        S_FINISH: begin
          if (!result_valid || result_take) begin
            result.drive     <= last_drive;
            result.evaluated <= evaluated;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FINISH)
    else $error("result beat raised outside finish");

  a_eval_needs_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.evaluated |-> has_run)
    else $error("evaluated result before first run");

  a_factor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> factor != '0)
    else $error("divide by zero factor");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= pidtc_pkg::CntW'(pidtc_pkg::DivSteps))
    else $error("step counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("pending result overwritten");

endmodule

// File: tb/pid_controller_time_corrected_test.sv
// ----------------------------------------------------------------------------
// pid_controller_time_corrected_test: self-checking bench for the pid regulator
// A directed table covers the sample window edges, saturation at both ends,
// time wrap, the elapsed time cap, target changes and every register. After it
// come random phases, each with its own register setting. Every accepted beat
// is folded into a cycle-free software model of the regulator, and each
// result beat is compared with the oldest prediction. The sender works in
// bursts and the receiver stalls in segments, including long holds.
// ----------------------------------------------------------------------------
module pid_controller_time_corrected_test;

  localparam logic OpSample   = 1'b0;
  localparam logic OpRetarget = 1'b1;
  localparam logic [pidtc_pkg::CfgIdxW-1:0] RegUnmapped = 3'd7;

  localparam longint QOne        = 65536;
  localparam longint FactorLimit = 65535;
  localparam int PlanLen       = 37;
  localparam int PhaseCount    = 7;
  localparam int PhaseItems    = 250;
  localparam int HoldoffCycles = 400;
  localparam int ReportMax     = 10;
  localparam int TailCycles    = 24;

  typedef enum logic [1:0] {RowSample, RowRetarget, RowWrite} row_kind_t;
  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy} stall_mode_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [pidtc_pkg::CfgIdxW-1:0] idx;
    logic [31:0]                   now_ms;
    logic [31:0]                   data;
    logic                          clr;
    logic                          typed;
    logic [31:0]                   want_drive;
    logic                          want_eval;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                            item_valid = 1'b0;
  logic                            item_stall;
  pidtc_pkg::pidtc_item_t          item = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  pidtc_pkg::pidtc_result_t        result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pidtc_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [pidtc_pkg::DataW-1:0]     cfg_data = '0;

  pid_controller_time_corrected dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // regulator registers as seen by the model
  longint      kp = 0;
  longint      ki = 0;
  longint      kd = 0;
  longint      lim_q = 0;
  logic [15:0] min_ms = pidtc_pkg::MinSampleReset;
  bit          tc_on = 1'b1;

  // regulator state
  longint      set_pt = 0;
  longint      integ_acc = 0;
  longint      prev_err = 0;
  longint      last_drv = 0;
  logic [31:0] last_upd_ms = '0;
  bit          ran = 1'b0;

  pidtc_pkg::pidtc_result_t drive_q[$];
  pidtc_pkg::pidtc_result_t oldest;
  plan_row_t     plan [PlanLen];
  logic [31:0]   wall_ms = '0;
  int            burst_left = 0;

  int n_items = 0;
  int n_evals = 0;
  int n_retargets = 0;
  int n_writes = 0;
  int n_holdoffs = 0;
  int n_fail = 0;

  function automatic longint clamp32(input longint v);
    if (v > longint'(pidtc_pkg::SatMax)) return longint'(pidtc_pkg::SatMax);
    if (v < longint'(pidtc_pkg::SatMin)) return longint'(pidtc_pkg::SatMin);
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clamp32((a * b) / QOne);
  endfunction

  function automatic int sgn(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  task automatic fold_item(input pidtc_pkg::pidtc_item_t it,
                           output pidtc_pkg::pidtc_result_t res);
    logic [31:0] elapsed;
    longint factor, err, p, d, diff, mag, step, tgt;
    res.evaluated = 1'b0;
    if (it.op == OpRetarget) begin
      tgt = longint'($signed(it.new_target));
      prev_err = clamp32(prev_err + (tgt - set_pt));
      set_pt = tgt;
      last_upd_ms = it.now_ms;
      if (it.clear_integral) begin
        integ_acc = 0;
      end
    end else begin
      elapsed = it.now_ms - last_upd_ms;
      if (elapsed > {16'd0, min_ms}) begin
        factor = 1;
        if (tc_on) begin
          factor = (longint'(elapsed) > FactorLimit) ? FactorLimit : longint'(elapsed);
        end
        last_upd_ms = it.now_ms;
        err = clamp32(set_pt - longint'($signed(it.measurement)));
        p = qmul(kp, err);
        d = 0;
        // first evaluation after reset has no integral or derivative history
        if (ran) begin
          mag = (last_drv < 0) ? -last_drv : last_drv;
          if (lim_q == 0 || mag < lim_q || sgn(ki * err) != sgn(last_drv)) begin
            step = clamp32(qmul(ki, err) * factor);
            integ_acc = clamp32(integ_acc + step);
          end
          diff = clamp32(err - prev_err);
          d = clamp32((kd * diff) / (factor * QOne));
        end
        last_drv = clamp32(p + integ_acc + d);
        prev_err = err;
        ran = 1'b1;
        res.evaluated = 1'b1;
      end
    end
    res.drive = last_drv[31:0];
  endtask

  task automatic apply_write(input logic [pidtc_pkg::CfgIdxW-1:0] idx,
                             input logic [31:0] data);
    case (idx)
      pidtc_pkg::RegGainP: begin
        kp = longint'($signed(data));
      end
      pidtc_pkg::RegGainI: begin
        ki = longint'($signed(data));
      end
      pidtc_pkg::RegGainD: begin
        kd = longint'($signed(data));
      end
      pidtc_pkg::RegMinSample: begin
        min_ms = data[15:0];
      end
      pidtc_pkg::RegIntegralLimit: begin
        lim_q = longint'(data[30:0]);
      end
      pidtc_pkg::RegTimeCorr: begin
        tc_on = data[0];
      end
      // writes to the initial target register have no effect on the setpoint
      default: begin
      end
    endcase
  endtask

  task automatic note_fail(input string what, input logic [31:0] want, input logic [31:0] got);
    n_fail++;
    if (n_fail <= ReportMax) begin
      $display("mismatch %s: expected %h got %h", what, want, got);
    end
  endtask

  task automatic offer(input pidtc_pkg::pidtc_item_t it, input bit typed,
                       input pidtc_pkg::pidtc_result_t typed_res);
    pidtc_pkg::pidtc_result_t want;
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    fold_item(it, want);
    drive_q.push_back(typed ? typed_res : want);
    n_items++;
    if (want.evaluated) n_evals++;
    if (it.op == OpRetarget) n_retargets++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    item_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pidtc_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_write(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      v = $urandom_range(0, 32'h0008_0000);
      return v - 32'h0004_0000;
    end
    if (r < 8) begin
      v = $urandom_range(0, 32'h0100_0000);
      return v - 32'h0080_0000;
    end
    return $urandom;
  endfunction

  task automatic load_phase(input int ph);
    logic [31:0] lim_data;
    logic [15:0] min_low;
    int r;
    if (ph == 0) begin
      write_reg(pidtc_pkg::RegGainP, pidtc_pkg::SatMin);
      write_reg(pidtc_pkg::RegGainI, pidtc_pkg::SatMin);
      write_reg(pidtc_pkg::RegGainD, pidtc_pkg::SatMin);
      write_reg(pidtc_pkg::RegMinSample, 32'hFFFF_0000);
      write_reg(pidtc_pkg::RegIntegralLimit, 32'h8000_0000);
      write_reg(pidtc_pkg::RegTimeCorr, 32'hFFFF_FFFE);
      write_reg(pidtc_pkg::RegInitTarget, pidtc_pkg::SatMin);
    end else if (ph == 1) begin
      write_reg(pidtc_pkg::RegGainP, pidtc_pkg::SatMax);
      write_reg(pidtc_pkg::RegGainI, pidtc_pkg::SatMax);
      write_reg(pidtc_pkg::RegGainD, pidtc_pkg::SatMax);
      write_reg(pidtc_pkg::RegMinSample, 32'h0000_FFFF);
      write_reg(pidtc_pkg::RegIntegralLimit, pidtc_pkg::SatMax);
      write_reg(pidtc_pkg::RegTimeCorr, 32'h1);
      write_reg(pidtc_pkg::RegInitTarget, pidtc_pkg::SatMax);
    end else begin
      write_reg(pidtc_pkg::RegGainP, pick_gain());
      write_reg(pidtc_pkg::RegGainI, pick_gain());
      write_reg(pidtc_pkg::RegGainD, pick_gain());
      r = $urandom_range(0, 9);
      min_low = (r < 6) ? 16'($urandom_range(0, 20)) :
                ((r < 8) ? 16'($urandom_range(0, 1000)) : 16'($urandom_range(0, 16'hFFFF)));
      write_reg(pidtc_pkg::RegMinSample, {16'($urandom_range(0, 16'hFFFF)), min_low});
      r = $urandom_range(0, 9);
      lim_data = (r < 3) ? 32'h0 : ((r < 7) ? $urandom_range(1, 32'h0040_0000) : $urandom);
      write_reg(pidtc_pkg::RegIntegralLimit, lim_data);
      write_reg(pidtc_pkg::RegTimeCorr, $urandom);
      write_reg(pidtc_pkg::RegInitTarget, $urandom);
      if (ph % 2 == 0) begin
        write_reg(RegUnmapped, $urandom);
      end
    end
  endtask

  task automatic next_item(output pidtc_pkg::pidtc_item_t it);
    int r;
    logic [31:0] step_ms;
    logic [31:0] jitter;
    r = $urandom_range(0, 99);
    if (r < 70) step_ms = min_ms + 1 + $urandom_range(0, 30);
    else if (r < 85) step_ms = $urandom_range(0, min_ms);
    else if (r < 95) step_ms = $urandom_range(0, 200000);
    else step_ms = $urandom;
    wall_ms = wall_ms + step_ms;
    it.now_ms = wall_ms;
    it.op = ($urandom_range(0, 9) == 0) ? OpRetarget : OpSample;
    it.clear_integral = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      jitter = $urandom_range(0, 32'h0004_0000);
      it.measurement = set_pt[31:0] + jitter - 32'h0002_0000;
    end else if (r < 85) begin
      it.measurement = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: it.measurement = pidtc_pkg::SatMax;
        1: it.measurement = pidtc_pkg::SatMin;
        2: it.measurement = '0;
        default: it.measurement = '1;
      endcase
    end
    if ($urandom_range(0, 9) < 7) begin
      jitter = $urandom_range(0, 32'h0020_0000);
      it.new_target = jitter - 32'h0010_0000;
    end else begin
      it.new_target = $urandom;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #15_000_000;
    $display("pid_controller_time_corrected verification failed");
    $finish;
  end

  // receiver: stall segments of random style, with a long hold now and then
  initial begin
    int seg;
    int span;
    stall_mode_t mode;
    seg = 0;
    forever begin
      seg++;
      if (seg % 30 == 4) begin
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (HoldoffCycles - 1) @(negedge clk);
        n_holdoffs++;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 2));
        span = $urandom_range(10, 150);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            StallNone: result_stall <= 1'b0;
            StallLight: result_stall <= ($urandom_range(0, 2) == 0);
            default: result_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (drive_q.size() == 0) begin
        note_fail("unexpected result beat", '0, result.drive);
      end else begin
        oldest = drive_q.pop_front();
        if (result.drive !== oldest.drive) begin
          note_fail("drive", oldest.drive, result.drive);
        end
        if (result.evaluated !== oldest.evaluated) begin
          note_fail("evaluated", {31'd0, oldest.evaluated}, {31'd0, result.evaluated});
        end
      end
    end
  end

  initial begin
    plan_row_t row;
    pidtc_pkg::pidtc_item_t it;
    pidtc_pkg::pidtc_result_t typed_res;
    int k;
    int ph;

    plan = '{
      // sample window edges with reset registers
      '{RowSample,   '0, 32'd5,   32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0, 1'b0},
      '{RowSample,   '0, 32'd10,  32'h8000_0000, 1'b0, 1'b1, 32'h0, 1'b0},
      '{RowSample,   '0, 32'd11,  32'h0,         1'b0, 1'b1, 32'h0, 1'b1},
      '{RowWrite, pidtc_pkg::RegGainP, '0, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      // saturation at both ends with unit proportional gain
      '{RowSample,   '0, 32'd22,  32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{RowSample,   '0, 32'd23,  32'h0,         1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{RowSample,   '0, 32'd100, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0001, 1'b1},
      '{RowRetarget, '0, 32'd200, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0001, 1'b0},
      '{RowWrite, pidtc_pkg::RegGainP, '0,         32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegGainI, '0,         32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegGainD, '0,         32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegIntegralLimit, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegTimeCorr, '0,      32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegMinSample, '0,     32'hFFFF_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      // zero window, same time as the retarget
      '{RowSample,   '0, 32'd200,        32'h0,         1'b0, 1'b1, 32'h8000_0001, 1'b0},
      '{RowSample,   '0, 32'd201,        32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'd202,        32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowRetarget, '0, 32'd203,        32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'hFFFF_FFFF,  32'h1234_5678, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegTimeCorr, '0,       32'h1,         1'b0, 1'b0, 32'h0, 1'b0},
      // time wraps, then a gap past the elapsed cap
      '{RowSample,   '0, 32'd3,          32'hEDCB_A987, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0010_0003,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegGainP, '0,          32'h0000_8000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegGainI, '0,          32'h0000_1000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegGainD, '0,          32'h0002_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegIntegralLimit, '0,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
      // tiny limit: integration only where signs differ or the last drive is zero
      '{RowSample,   '0, 32'h0010_0010,  32'h0005_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0010_0020,  32'hFFFB_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0010_0030,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
      '{RowRetarget, '0, 32'h0010_0040,  32'h0003_0000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0010_0050,  32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegMinSample, '0,      32'h0000_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0011_0050,  32'h0002_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0012_004F,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, pidtc_pkg::RegInitTarget, '0,     32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowWrite, RegUnmapped, '0,       32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{RowSample,   '0, 32'h0013_0051,  32'hFFFF_0000, 1'b0, 1'b0, 32'h0, 1'b0}
    };

    wait (!rst);
    for (k = 0; k < PlanLen; k++) begin
      row = plan[k];
      if (row.kind == RowWrite) begin
        quiesce();
        write_reg(row.idx, row.data);
      end else begin
        it.op = (row.kind == RowRetarget) ? OpRetarget : OpSample;
        it.now_ms = row.now_ms;
        it.measurement = (row.kind == RowSample) ? row.data : $urandom;
        it.new_target = (row.kind == RowRetarget) ? row.data : $urandom;
        it.clear_integral = (row.kind == RowRetarget) ? row.clr : 1'($urandom_range(0, 1));
        typed_res.drive = row.want_drive;
        typed_res.evaluated = row.want_eval;
        offer(it, row.typed, typed_res);
        wall_ms = row.now_ms;
        pace();
      end
    end

    for (ph = 0; ph < PhaseCount; ph++) begin
      quiesce();
      load_phase(ph);
      repeat (PhaseItems) begin
        next_item(it);
        offer(it, 1'b0, typed_res);
        pace();
      end
    end

    quiesce();
    repeat (TailCycles) @(posedge clk);
    $display("ran %0d sample and target beats: %0d evaluations, %0d target changes",
             n_items, n_evals, n_retargets);
    $display("%0d register writes, %0d long output holds, %0d mismatches",
             n_writes, n_holdoffs, n_fail);
    if (n_fail == 0 && drive_q.size() == 0) begin
      $display("pid_controller_time_corrected verification clean");
    end else begin
      $display("pid_controller_time_corrected verification failed");
    end
    $finish;
  end

endmodule
